FILE: src/glcd_pkg.sv
// ----------------------------------------------------------------------------
// glcd_pkg
// Shared constants, codes and controller/datapath types for the two-half
// graphic LCD refresh engine.
// ----------------------------------------------------------------------------
package glcd_pkg;

  localparam int STORE_BYTES  = 1024;
  localparam int PLOT_COLUMNS = 100;
  localparam int ROW_BYTES    = 128;

  localparam int ADDR_W       = $clog2(STORE_BYTES);
  localparam int SAMPLE_DEPTH = 128;
  localparam int SIDX_W       = $clog2(SAMPLE_DEPTH);
  localparam int COL_W        = 8;
  localparam int PAGE_W       = 3;
  localparam int REQ_W        = 3;
  localparam int BYTE_W       = 8;

  localparam int PLOT_BASE    = 996;
  localparam int HALF_COLUMNS = 64;
  localparam int MAX_HEIGHT   = 63;
  localparam int INIT_COUNT   = 4;

  localparam logic [BYTE_W-1:0] CMD_START_LINE  = 8'b1100_0000;
  localparam logic [BYTE_W-1:0] CMD_COLUMN_ZERO = 8'b0100_0000;
  localparam logic [BYTE_W-1:0] CMD_PAGE        = 8'b1011_1000;
  localparam logic [BYTE_W-1:0] CMD_DISPLAY_ON  = 8'b0011_1111;
  localparam logic [BYTE_W-1:0] TOP_BIT         = 8'b1000_0000;

  localparam logic [REQ_W-1:0] REQ_INIT    = 3'd0;
  localparam logic [REQ_W-1:0] REQ_LOAD    = 3'd1;
  localparam logic [REQ_W-1:0] REQ_STORE   = 3'd2;
  localparam logic [REQ_W-1:0] REQ_PLOT    = 3'd3;
  localparam logic [REQ_W-1:0] REQ_REFRESH = 3'd4;

  // Source of one bus write
  typedef enum logic [1:0] {
    OUT_INIT,
    OUT_PAGE,
    OUT_COL,
    OUT_DATA
  } out_kind_t;

  typedef struct packed {
    logic      emit;
    out_kind_t kind;
    logic [1:0] init_idx;
    logic      frame_load;
    logic      sample_store;
    logic      scan_read;
    logic      scan_wrap;
    logic      plot_start;
    logic      sample_read;
    logic      plot_read;
    logic      plot_write;
  } glcd_cmd_t;

  typedef struct packed {
    logic col_wrap;
    logic plot_last;
  } glcd_sts_t;

  function automatic logic [BYTE_W-1:0] init_cmd(input logic [1:0] idx);
    logic [BYTE_W-1:0] b;
    case (idx)
      2'd0:    b = CMD_START_LINE;
      2'd1:    b = CMD_COLUMN_ZERO;
      2'd2:    b = CMD_PAGE;
      default: b = CMD_DISPLAY_ON;
    endcase
    return b;
  endfunction

endpackage

FILE: src/glcd_waveform_framebuffer_refresh.sv
// ----------------------------------------------------------------------------
// glcd_waveform_framebuffer_refresh
// Refresh engine for a 128x64 graphic LCD split over two controllers, with a
// byte-wide frame store and a waveform sample store.
// ----------------------------------------------------------------------------
//
//  Channel  Direction  Handshake          Transaction
//  in_      input      in_valid/in_stall  one request (init, load, store,
//                                         plot, refresh)
//  out_     output     out_valid/out_stall one LCD bus write
//
//  Load and store finish in the accept cycle; the next request is taken right
//  after. Init sends its four init commands after the accept cycle, one bus
//  write each. Refresh reads the frame store in the accept cycle, then sends
//  the data write, preceded by a page and a column command on a column wrap.
//  Plot steps each of the 100 plotted columns through a sample read, a frame
//  store read and a write back to the frame store.
//  Reset clears the sequencer, result valid and the scan position; both
//  stores come up undefined and have no clearing pass.
//  A stalled result holds each bus write step, which stretches the request.
//
module glcd_waveform_framebuffer_refresh (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [glcd_pkg::REQ_W-1:0]    in_req_type,
  input  logic [glcd_pkg::ADDR_W-1:0]   in_fb_address,
  input  logic [glcd_pkg::BYTE_W-1:0]   in_fb_byte,
  input  logic [glcd_pkg::SIDX_W-1:0]   in_sample_index,
  input  logic [glcd_pkg::BYTE_W-1:0]   in_sample_value,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic                          out_cs_left,
  output logic                          out_cs_right,
  output logic                          out_reg_select,
  output logic [glcd_pkg::BYTE_W-1:0]   out_bus_byte,
  output logic                          out_last
);
  import glcd_pkg::*;

  glcd_cmd_t cmd;
  glcd_sts_t sts;

  // Sequencer: decode transactions and step each request
  glcd_ctrl u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_req_type (in_req_type),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .sts         (sts),
    .cmd         (cmd)
  );

  // Stores, scan position and the result register
  glcd_dp u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .sts             (sts),
    .in_fb_address   (in_fb_address),
    .in_fb_byte      (in_fb_byte),
    .in_sample_index (in_sample_index),
    .in_sample_value (in_sample_value),
    .out_cs_left     (out_cs_left),
    .out_cs_right    (out_cs_right),
    .out_reg_select  (out_reg_select),
    .out_bus_byte    (out_bus_byte),
    .out_last        (out_last)
  );

  // Never overwrite a result that is still waiting
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |-> (!out_valid || !out_stall))
    else $error("result overwritten while stalled");

  // Command writes always go to both halves
  a_cmd_both: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_reg_select) |-> (out_cs_left && out_cs_right))
    else $error("command write not sent to both halves");

  // A data write ends its request and selects exactly one half
  a_data_one_half: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_reg_select) |-> (out_last && (out_cs_left != out_cs_right)))
    else $error("bad data write select");

  // Requests that produce bus writes or plot hold off the next transaction
  a_busy_after: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall && (in_req_type == REQ_INIT || in_req_type == REQ_PLOT
      || in_req_type == REQ_REFRESH)) |=> in_stall)
    else $error("request accepted while busy");

endmodule

FILE: src/glcd_ctrl.sv
// ----------------------------------------------------------------------------
// glcd_ctrl
// Request sequencer: decodes transactions, steps init, refresh and plot, and
// owns the result valid flag.
// ----------------------------------------------------------------------------
module glcd_ctrl (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [glcd_pkg::REQ_W-1:0]   in_req_type,
  output logic                         out_valid,
  input  logic                         out_stall,
  input  glcd_pkg::glcd_sts_t          sts,
  output glcd_pkg::glcd_cmd_t          cmd
);
  import glcd_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_INIT,
    S_RF_PAGE,
    S_RF_COL,
    S_RF_DATA,
    S_PL_RS,
    S_PL_RF,
    S_PL_WR
  } state_t;

  state_t     state_r, state_nxt;
  logic [1:0] idx_r, idx_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       out_free;

  assign out_free  = !out_valid_r || !out_stall;
  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt = state_r;
    idx_nxt   = idx_r;
    cmd       = '0;
    cmd.kind  = OUT_INIT;
    cmd.init_idx = idx_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          case (in_req_type)
            REQ_INIT: begin
              idx_nxt   = 2'd0;
              state_nxt = S_INIT;
            end
            REQ_LOAD:  cmd.frame_load   = 1'b1;
            REQ_STORE: cmd.sample_store = 1'b1;
            REQ_PLOT: begin
              cmd.plot_start = 1'b1;
              state_nxt      = S_PL_RS;
            end
            REQ_REFRESH: begin
              cmd.scan_read = 1'b1;
              cmd.scan_wrap = sts.col_wrap;
              state_nxt     = sts.col_wrap ? S_RF_PAGE : S_RF_DATA;
            end
            default: ;
          endcase
        end
      end
      S_INIT: begin
        if (out_free) begin
          cmd.emit = 1'b1;
          cmd.kind = OUT_INIT;
          idx_nxt  = idx_r + 2'd1;
          if (idx_r == 2'(INIT_COUNT - 1)) state_nxt = S_IDLE;
        end
      end
      S_RF_PAGE: begin
        if (out_free) begin
          cmd.emit  = 1'b1;
          cmd.kind  = OUT_PAGE;
          state_nxt = S_RF_COL;
        end
      end
      S_RF_COL: begin
        if (out_free) begin
          cmd.emit  = 1'b1;
          cmd.kind  = OUT_COL;
          state_nxt = S_RF_DATA;
        end
      end
      S_RF_DATA: begin
        if (out_free) begin
          cmd.emit  = 1'b1;
          cmd.kind  = OUT_DATA;
          state_nxt = S_IDLE;
        end
      end
      S_PL_RS: begin
        cmd.sample_read = 1'b1;
        state_nxt       = S_PL_RF;
      end
      S_PL_RF: begin
        cmd.plot_read = 1'b1;
        state_nxt     = S_PL_WR;
      end
      S_PL_WR: begin
        cmd.plot_write = 1'b1;
        state_nxt      = sts.plot_last ? S_IDLE : S_PL_RS;
      end
      default: state_nxt = S_IDLE;
    endcase

    if (cmd.emit) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      idx_r       <= 2'd0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      idx_r       <= idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

FILE: src/glcd_dp.sv
// ----------------------------------------------------------------------------
// glcd_dp
// Frame store, sample store, scan position, plot pipeline registers and the
// result register.
// ----------------------------------------------------------------------------
module glcd_dp (
  input  logic                          clk,
  input  logic                          rst_n,
  input  glcd_pkg::glcd_cmd_t           cmd,
  output glcd_pkg::glcd_sts_t           sts,
  input  logic [glcd_pkg::ADDR_W-1:0]   in_fb_address,
  input  logic [glcd_pkg::BYTE_W-1:0]   in_fb_byte,
  input  logic [glcd_pkg::SIDX_W-1:0]   in_sample_index,
  input  logic [glcd_pkg::BYTE_W-1:0]   in_sample_value,
  output logic                          out_cs_left,
  output logic                          out_cs_right,
  output logic                          out_reg_select,
  output logic [glcd_pkg::BYTE_W-1:0]   out_bus_byte,
  output logic                          out_last
);
  import glcd_pkg::*;

  logic [BYTE_W-1:0] frame_mem [STORE_BYTES];
  logic [BYTE_W-1:0] sample_mem [SAMPLE_DEPTH];

  logic [BYTE_W-1:0] frame_rd_r;
  logic [BYTE_W-1:0] sample_rd_r;

  logic [COL_W-1:0]  col_r, col_nxt;
  logic [PAGE_W-1:0] page_r, page_nxt;
  logic [ADDR_W-1:0] scan_addr_r, scan_addr_nxt;

  logic [SIDX_W-1:0] plot_col_r, plot_col_nxt;
  logic [ADDR_W-1:0] plot_addr_r;
  logic [BYTE_W-1:0] plot_mask_r;

  logic [5:0]        hgt;
  logic [ADDR_W-1:0] plot_addr;
  logic [BYTE_W-1:0] plot_mask;

  logic              fr_we;
  logic [ADDR_W-1:0] fr_wa;
  logic [BYTE_W-1:0] fr_wd;
  logic              fr_re;
  logic [ADDR_W-1:0] fr_ra;

  logic              left;

  assign sts.col_wrap  = (col_r >= COL_W'(ROW_BYTES));
  assign sts.plot_last = (plot_col_r == SIDX_W'(PLOT_COLUMNS - 1));

  // Clamp height to the panel, then split into page row and pixel bit
  assign hgt       = (sample_rd_r > BYTE_W'(MAX_HEIGHT)) ? 6'(MAX_HEIGHT) : sample_rd_r[5:0];
  assign plot_addr = ADDR_W'(PLOT_BASE) - ADDR_W'(ROW_BYTES * int'(hgt[5:3]))
                   - ADDR_W'(plot_col_r);
  assign plot_mask = TOP_BIT >> hgt[2:0];

  always_comb begin
    fr_we = cmd.frame_load || cmd.plot_write;
    fr_wa = cmd.frame_load ? in_fb_address : plot_addr_r;
    fr_wd = cmd.frame_load ? in_fb_byte : (frame_rd_r | plot_mask_r);
    fr_re = cmd.scan_read || cmd.plot_read;
    fr_ra = cmd.plot_read ? plot_addr : scan_addr_r;
  end

  always_ff @(posedge clk) begin
    if (fr_we) frame_mem[fr_wa] <= fr_wd;
    if (fr_re) frame_rd_r <= frame_mem[fr_ra];
  end

  always_ff @(posedge clk) begin
    if (cmd.sample_store) sample_mem[in_sample_index] <= in_sample_value;
    if (cmd.sample_read)  sample_rd_r <= sample_mem[plot_col_r];
  end

  always_ff @(posedge clk) begin
    if (cmd.plot_read) begin
      plot_addr_r <= plot_addr;
      plot_mask_r <= plot_mask;
    end
  end

  assign left = (col_r < COL_W'(HALF_COLUMNS));

  always_comb begin
    col_nxt       = col_r;
    page_nxt      = page_r;
    scan_addr_nxt = scan_addr_r;
    plot_col_nxt  = plot_col_r;
    if (cmd.scan_wrap) begin
      col_nxt  = '0;
      page_nxt = page_r + PAGE_W'(1);
    end
    if (cmd.emit && cmd.kind == OUT_DATA) begin
      col_nxt       = col_r + COL_W'(1);
      scan_addr_nxt = scan_addr_r + ADDR_W'(1);
    end
    if (cmd.plot_start) plot_col_nxt = '0;
    if (cmd.plot_write) plot_col_nxt = plot_col_r + SIDX_W'(1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r       <= '0;
      page_r      <= '0;
      scan_addr_r <= '0;
      plot_col_r  <= '0;
    end else begin
      col_r       <= col_nxt;
      page_r      <= page_nxt;
      scan_addr_r <= scan_addr_nxt;
      plot_col_r  <= plot_col_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      case (cmd.kind)
        OUT_INIT: begin
          out_cs_left    <= 1'b1;
          out_cs_right   <= 1'b1;
          out_reg_select <= 1'b0;
          out_bus_byte   <= init_cmd(cmd.init_idx);
          out_last       <= (cmd.init_idx == 2'(INIT_COUNT - 1));
        end
        OUT_PAGE: begin
          out_cs_left    <= 1'b1;
          out_cs_right   <= 1'b1;
          out_reg_select <= 1'b0;
          out_bus_byte   <= CMD_PAGE | BYTE_W'(page_r);
          out_last       <= 1'b0;
        end
        OUT_COL: begin
          out_cs_left    <= 1'b1;
          out_cs_right   <= 1'b1;
          out_reg_select <= 1'b0;
          out_bus_byte   <= CMD_COLUMN_ZERO;
          out_last       <= 1'b0;
        end
        default: begin
          out_cs_left    <= left;
          out_cs_right   <= !left;
          out_reg_select <= 1'b1;
          out_bus_byte   <= frame_rd_r;
          out_last       <= 1'b1;
        end
      endcase
    end
  end

endmodule
